### rtl/ecg_r_peak_detector_top_defines.svh
// Assertion macros shared by the ECG R-peak detector modules
`ifndef ECG_R_PEAK_DETECTOR_TOP_DEFINES_SVH
`define ECG_R_PEAK_DETECTOR_TOP_DEFINES_SVH

// implication checked every cycle outside reset
`define ERPD_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// implication whose right side is checked in the following cycle
`define ERPD_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

### rtl/erpd_pkg.sv
// Types, constants and fixed-point helpers of the ECG R-peak detector
package erpd_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int FRAC_BITS   = 16;
   localparam int Q_BITS      = 48;
   localparam int K_BITS      = FRAC_BITS + 1;
   localparam int CNT_BITS    = 16;
   localparam int SUM_BITS    = 29;
   localparam int WCNT_BITS   = 5;
   localparam int DIV_STEPS   = SUM_BITS;

   localparam longint Q_ONE = longint'(1) << FRAC_BITS;
   localparam longint K90   = (9 * Q_ONE + 5) / 10;
   localparam longint K10   = Q_ONE - K90;
   localparam longint K95   = (19 * Q_ONE + 10) / 20;
   localparam longint K05   = Q_ONE - K95;
   localparam longint K999  = (999 * Q_ONE + 500) / 1000;

   localparam logic [K_BITS-1:0] K90_Q  = K_BITS'(K90);
   localparam logic [K_BITS-1:0] K10_Q  = K_BITS'(K10);
   localparam logic [K_BITS-1:0] K95_Q  = K_BITS'(K95);
   localparam logic [K_BITS-1:0] K05_Q  = K_BITS'(K05);
   localparam logic [K_BITS-1:0] K999_Q = K_BITS'(K999);

   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DECIM  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PAIR   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SETTLE = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REFR   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAXIV  = 3'd4;

   // datapath operation selected by the controller
   typedef enum logic [7:0] {
      OP_NONE   = 8'b0000_0001,
      OP_LOAD   = 8'b0000_0010,
      OP_SMOOTH = 8'b0000_0100,
      OP_SLOPE  = 8'b0000_1000,
      OP_DECAY  = 8'b0001_0000,
      OP_PEAK   = 8'b0010_0000,
      OP_DIV    = 8'b0100_0000,
      OP_FINISH = 8'b1000_0000
   } op_type;

   typedef struct packed {
      op_type op;
      logic   div_start;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic win_end;
   } status_type;

   typedef struct packed {
      logic [4:0]  decimation_length;
      logic [7:0]  pair_window;
      logic [7:0]  settle_delay;
      logic [9:0]  refractory_ms;
      logic [15:0] max_interval_ms;
   } cfg_type;

   // floor(a * k / ONE); one multiplier per call, registered afterwards by caller
   function automatic logic signed [Q_BITS-1:0] mulq(input logic signed [Q_BITS-1:0] a,
                                                      input logic [K_BITS-1:0] k);
      logic signed [Q_BITS+K_BITS:0] p;
      begin
         p = a * $signed({1'b0, k});
         mulq = p[FRAC_BITS +: Q_BITS];
      end
   endfunction

endpackage

### rtl/erpd_ctrl.sv
// Sequencer of the ECG R-peak detector: steps one sample through the datapath
`include "ecg_r_peak_detector_top_defines.svh"

module erpd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_fire,
   input  logic                   out_free,
   input  erpd_pkg::status_type   status,
   output logic                   in_ready,
   output logic                   out_load,
   output erpd_pkg::cmd_type      cmd
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_SMOOTH = 8'b0000_0010,
      ST_SLOPE  = 8'b0000_0100,
      ST_DECAY  = 8'b0000_1000,
      ST_PEAK   = 8'b0001_0000,
      ST_DIV    = 8'b0010_0000,
      ST_WAIT   = 8'b0100_0000,
      ST_OUT    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd.op        = erpd_pkg::OP_NONE;
      cmd.div_start = 1'b0;
      out_load      = 1'b0;
      in_ready      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_fire) begin
               cmd.op   = erpd_pkg::OP_LOAD;
               state_in = ST_SMOOTH;
            end
         end
         ST_SMOOTH: begin
            cmd.op   = erpd_pkg::OP_SMOOTH;
            state_in = ST_SLOPE;
         end
         ST_SLOPE: begin
            cmd.op   = erpd_pkg::OP_SLOPE;
            state_in = ST_DECAY;
         end
         ST_DECAY: begin
            cmd.op   = erpd_pkg::OP_DECAY;
            state_in = ST_PEAK;
         end
         ST_PEAK: begin
            cmd.op   = erpd_pkg::OP_PEAK;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op        = erpd_pkg::OP_DIV;
            cmd.div_start = status.win_end;
            state_in      = ST_WAIT;
         end
         ST_WAIT: begin
            if (!status.div_busy) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.op   = erpd_pkg::OP_FINISH;
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `ERPD_ASSERT_IMPL(a_ready_idle, clock, reset, in_ready, state_ff == ST_IDLE,
                     "ready outside idle")
   `ERPD_ASSERT_NEXT(a_fire_runs, clock, reset, in_fire && in_ready, state_ff == ST_SMOOTH,
                     "accepted transaction did not start")
   `ERPD_ASSERT_IMPL(a_load_free, clock, reset, out_load, out_free,
                     "result loaded over pending result")

endmodule

### rtl/erpd_datapath.sv
// Datapath of the ECG R-peak detector: filters, peak trackers, counters, window divider
`include "ecg_r_peak_detector_top_defines.svh"

module erpd_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  erpd_pkg::cmd_type                    cmd,
   input  erpd_pkg::cfg_type                    cfg,
   input  logic signed [erpd_pkg::SAMPLE_BITS-1:0] in_sample,
   input  logic [31:0]                          in_now_ms,
   output erpd_pkg::status_type                 status,
   output logic [erpd_pkg::SAMPLE_BITS+20-1:0]  result
);

   localparam int QB = erpd_pkg::Q_BITS;
   localparam int SB = erpd_pkg::SAMPLE_BITS;
   localparam int CB = erpd_pkg::CNT_BITS;
   localparam int WB = erpd_pkg::SUM_BITS;
   localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};
   localparam logic [1:0] SEL_QUOT = 2'd0;
   localparam logic [1:0] SEL_FALL = 2'd1;
   localparam logic [1:0] SEL_RISE = 2'd2;

   logic signed [QB-1:0] smooth_ff, smooth_in, prev_ff, prev_in;
   logic signed [QB-1:0] rise_avg_ff, rise_avg_in, fall_avg_ff, fall_avg_in;
   logic signed [QB-1:0] rise_pk_ff, rise_pk_in, fall_pk_ff, fall_pk_in;
   logic signed [QB-1:0] tmp_ff, tmp_in;
   logic [CB-1:0] since_r_ff, since_r_in, since_f_ff, since_f_in, since_b_ff, since_b_in;
   logic signed [SB-1:0] rise_smp_ff, rise_smp_in, fall_smp_ff, fall_smp_in;
   logic signed [SB-1:0] smp_ff, smp_in;
   logic [31:0] now_ff, now_in, last_ff, last_in;
   logic [erpd_pkg::WCNT_BITS-1:0] wcnt_ff, wcnt_in;
   logic signed [WB-1:0] wsum_ff, wsum_in;
   logic det_ff, det_in, acc_ff, acc_in, iv_ff, iv_in, dv_ff, dv_in;
   logic [15:0] ims_ff, ims_in;
   logic signed [SB-1:0] dval_ff, dval_in;
   logic [1:0] sel_ff, sel_in;   // window quotient, fall sample or rise sample

   // restoring divider on magnitude
   logic [WB-1:0] dq_ff, dq_in, drem_ff, drem_in;
   logic [4:0] dlen_ff, dlen_in;
   logic dneg_ff, dneg_in, dbusy_ff, dbusy_in;
   logic [4:0] dstep_ff, dstep_in;

   logic signed [QB-1:0] dv_q, mul_a, mul_b;
   logic [4:0] len;
   logic [31:0] gap;
   logic [CB-1:0] sr_inc, sf_inc;
   logic [WB:0] trial;
   logic signed [WB-1:0] wsum_new;
   logic [erpd_pkg::WCNT_BITS-1:0] wcnt_new;
   logic [SB-1:0] quot;

   assign dv_q  = smooth_ff - prev_ff;
   assign len   = (cfg.decimation_length == 5'd0) ? 5'd1 : cfg.decimation_length;
   assign gap   = now_ff - last_ff;
   assign sr_inc = (since_r_ff == CNT_MAX) ? CNT_MAX : since_r_ff + 1'b1;
   assign sf_inc = (since_f_ff == CNT_MAX) ? CNT_MAX : since_f_ff + 1'b1;
   assign wcnt_new = wcnt_ff + 5'd1;
   assign wsum_new = wsum_ff + WB'(smp_ff);
   assign trial = {drem_ff[WB-2:0], dq_ff[WB-1]} - {{(WB-4){1'b0}}, dlen_ff};
   assign quot = dneg_ff ? SB'(-dq_ff) : SB'(dq_ff);
   assign mul_a = erpd_pkg::mulq(cmd.op == erpd_pkg::OP_SMOOTH ? smooth_ff :
                     (cmd.op == erpd_pkg::OP_SLOPE ? rise_avg_ff : rise_pk_ff),
                     cmd.op == erpd_pkg::OP_SMOOTH ? erpd_pkg::K90_Q :
                     (cmd.op == erpd_pkg::OP_SLOPE ? erpd_pkg::K95_Q : erpd_pkg::K999_Q));
   assign mul_b = erpd_pkg::mulq(cmd.op == erpd_pkg::OP_SLOPE ? fall_avg_ff : fall_pk_ff,
                     cmd.op == erpd_pkg::OP_SLOPE ? erpd_pkg::K95_Q : erpd_pkg::K999_Q);

   always_comb begin
      smooth_in = smooth_ff;  prev_in = prev_ff;  tmp_in = tmp_ff;
      rise_avg_in = rise_avg_ff; fall_avg_in = fall_avg_ff;
      rise_pk_in = rise_pk_ff; fall_pk_in = fall_pk_ff;
      since_r_in = since_r_ff; since_f_in = since_f_ff; since_b_in = since_b_ff;
      rise_smp_in = rise_smp_ff; fall_smp_in = fall_smp_ff;
      smp_in = smp_ff; now_in = now_ff; last_in = last_ff;
      wcnt_in = wcnt_ff; wsum_in = wsum_ff;
      det_in = det_ff; acc_in = acc_ff; iv_in = iv_ff; ims_in = ims_ff;
      dv_in = dv_ff; dval_in = dval_ff; sel_in = sel_ff;
      dq_in = dq_ff; drem_in = drem_ff; dlen_in = dlen_ff; dneg_in = dneg_ff;
      dbusy_in = dbusy_ff; dstep_in = dstep_ff;
      case (cmd.op)
         erpd_pkg::OP_LOAD: begin
            smp_in = in_sample;
            now_in = in_now_ms;
            det_in = 1'b0; acc_in = 1'b0; iv_in = 1'b0; ims_in = '0;
            dv_in = 1'b0; dval_in = '0;
         end
         erpd_pkg::OP_SMOOTH: begin
            prev_in   = smooth_ff;
            smooth_in = mul_a + QB'(smp_ff * $signed({1'b0, erpd_pkg::K10_Q}));
         end
         erpd_pkg::OP_SLOPE: begin
            rise_avg_in = mul_a;
            fall_avg_in = mul_b;
            tmp_in = (dv_q > 0) ? dv_q : -dv_q;
         end
         erpd_pkg::OP_DECAY: begin
            if (dv_q > 0) rise_avg_in = rise_avg_ff + erpd_pkg::mulq(tmp_ff, erpd_pkg::K05_Q);
            else          fall_avg_in = fall_avg_ff + erpd_pkg::mulq(tmp_ff, erpd_pkg::K05_Q);
            rise_pk_in = mul_a;
            fall_pk_in = mul_b;
         end
         erpd_pkg::OP_PEAK: begin
            if (rise_avg_ff > rise_pk_ff) begin
               since_r_in = '0; rise_pk_in = rise_avg_ff; rise_smp_in = smp_ff;
               if (since_f_ff < CB'(cfg.pair_window)) det_in = 1'b1;
            end
            // a rise peak on this sample already cleared its counter
            if (fall_avg_ff > fall_pk_ff) begin
               since_f_in = '0; fall_pk_in = fall_avg_ff; fall_smp_in = smp_ff;
               if (since_r_in < CB'(cfg.pair_window)) det_in = 1'b1;
            end
         end
         erpd_pkg::OP_DIV: begin
            // det_ff is final here; peak counters already cleared
            if (det_ff) begin
               since_b_in = 16'd1;
            end else begin
               since_b_in = (since_b_ff == CNT_MAX) ? CNT_MAX : since_b_ff + 1'b1;
            end
            if ((det_ff ? 16'd0 : since_b_ff) == CB'(cfg.settle_delay) &&
                gap > 32'(cfg.refractory_ms)) begin
               acc_in = 1'b1;
               last_in = now_ff;
               if (gap < 32'(cfg.max_interval_ms)) begin
                  iv_in = 1'b1; ims_in = gap[15:0];
               end
            end
            since_r_in = sr_inc;
            since_f_in = sf_inc;
            wcnt_in = wcnt_new;
            wsum_in = wsum_new;
            if (status.win_end) begin
               wcnt_in = '0; wsum_in = '0; dv_in = 1'b1;
               sel_in = (sr_inc <= CB'(len)) ? SEL_RISE :
                        ((sf_inc <= CB'(len)) ? SEL_FALL : SEL_QUOT);
               dneg_in = wsum_new < 0;
               dq_in = wsum_new < 0 ? WB'(-wsum_new) : WB'(wsum_new);
               drem_in = '0; dlen_in = len; dstep_in = '0;
               dbusy_in = cmd.div_start;
            end
         end
         erpd_pkg::OP_FINISH: begin
            if (dv_ff) begin
               dval_in = (sel_ff == SEL_RISE) ? rise_smp_ff :
                         (sel_ff == SEL_FALL) ? fall_smp_ff : quot;
            end
         end
         default: ;
      endcase
      if (dbusy_ff) begin
         if (!trial[WB]) drem_in = trial[WB-1:0];
         else            drem_in = {drem_ff[WB-2:0], dq_ff[WB-1]};
         dq_in = {dq_ff[WB-2:0], ~trial[WB]};
         dstep_in = dstep_ff + 5'd1;
         if (dstep_ff == 5'(erpd_pkg::DIV_STEPS - 1)) dbusy_in = 1'b0;
      end
   end

   assign status.win_end  = (wcnt_new >= len);
   assign status.div_busy = dbusy_ff;
   // the decimated value is picked in the finish step, as the result is loaded
   assign result = {dval_in, dv_ff, ims_ff, iv_ff, acc_ff, det_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff <= '0; prev_ff <= '0; rise_avg_ff <= '0; fall_avg_ff <= '0;
         rise_pk_ff <= '0; fall_pk_ff <= '0;
         since_r_ff <= '0; since_f_ff <= '0; since_b_ff <= '0;
         rise_smp_ff <= '0; fall_smp_ff <= '0; last_ff <= '0;
         wcnt_ff <= '0; wsum_ff <= '0; dbusy_ff <= 1'b0; dstep_ff <= '0;
      end else begin
         smooth_ff <= smooth_in; prev_ff <= prev_in;
         rise_avg_ff <= rise_avg_in; fall_avg_ff <= fall_avg_in;
         rise_pk_ff <= rise_pk_in; fall_pk_ff <= fall_pk_in;
         since_r_ff <= since_r_in; since_f_ff <= since_f_in; since_b_ff <= since_b_in;
         rise_smp_ff <= rise_smp_in; fall_smp_ff <= fall_smp_in; last_ff <= last_in;
         wcnt_ff <= wcnt_in; wsum_ff <= wsum_in; dbusy_ff <= dbusy_in; dstep_ff <= dstep_in;
      end
   end

   always_ff @(posedge clock) begin
      tmp_ff <= tmp_in; smp_ff <= smp_in; now_ff <= now_in;
      det_ff <= det_in; acc_ff <= acc_in; iv_ff <= iv_in; ims_ff <= ims_in;
      dv_ff <= dv_in; dval_ff <= dval_in; sel_ff <= sel_in;
      dq_ff <= dq_in; drem_ff <= drem_in; dlen_ff <= dlen_in; dneg_ff <= dneg_in;
   end

   `ERPD_ASSERT_IMPL(a_iv_acc, clock, reset, iv_ff, acc_ff, "interval without accepted beat")
   `ERPD_ASSERT_IMPL(a_wcnt_len, clock, reset, cmd.op == erpd_pkg::OP_SLOPE,
                     wcnt_ff < 5'd31, "window count overrun")
   `ERPD_ASSERT_NEXT(a_div_start, clock, reset, cmd.div_start, dbusy_ff,
                     "divider did not start")

endmodule

### rtl/ecg_r_peak_detector_top.sv
// Top level of the ECG R-peak detector: ports, config registers, result register
//
//  channel | dir | contents
//  req_    | in  | tdata: sample[23:0], now_ms[55:24]
//  rsp_    | out | tdata: beat_detected, beat_accepted, interval_valid, interval_ms,
//          |     |        decimated_value[42:19]; tuser: decimated_valid
//  csr_    | in  | wr_en, index, wdata
//
// A sample steps from accept through smooth, slope, decay, peak, divide, wait and
// output; when a decimation window closes, the wait step holds until the 29-step
// divider is done. One sample is in flight at a time; a result waits in the output
// register while the next sample is accepted and processed, and the sequencer holds
// in output while it is full. Synchronous reset clears filters, peaks and counters.
module ecg_r_peak_detector_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [55:0]                           req_tdata,  // sample, now_ms
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [47:0]                           rsp_tdata,  // detected, accepted,
                                                             // ivalid, interval_ms, dvalue
   output logic                                  rsp_tuser,  // decimated_valid
   input  logic                                  csr_wr_en,
   input  logic [erpd_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [erpd_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   erpd_pkg::cfg_type cfg_ff, cfg_in;
   erpd_pkg::cmd_type cmd;
   erpd_pkg::status_type status;
   logic [erpd_pkg::SAMPLE_BITS+20-1:0] result;
   logic [erpd_pkg::SAMPLE_BITS+20-1:0] rsp_ff;
   logic rsp_valid_ff, rsp_valid_in, out_load, in_fire, in_ready, out_free;

   assign in_fire    = req_tvalid && in_ready;
   assign req_tready = in_ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            erpd_pkg::CSR_DECIM:  cfg_in.decimation_length = csr_wdata[4:0];
            erpd_pkg::CSR_PAIR:   cfg_in.pair_window       = csr_wdata[7:0];
            erpd_pkg::CSR_SETTLE: cfg_in.settle_delay      = csr_wdata[7:0];
            erpd_pkg::CSR_REFR:   cfg_in.refractory_ms     = csr_wdata[9:0];
            erpd_pkg::CSR_MAXIV:  cfg_in.max_interval_ms   = csr_wdata;
            default: ;
         endcase
      end
      rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{5'd8, 8'd70, 8'd30, 10'd150, 16'd2000};
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) rsp_ff <= result;
   end

   erpd_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_fire(in_fire), .out_free(out_free),
      .status(status), .in_ready(in_ready), .out_load(out_load), .cmd(cmd)
   );

   erpd_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .cfg(cfg_ff),
      .in_sample(req_tdata[23:0]), .in_now_ms(req_tdata[55:24]),
      .status(status), .result(result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff[43:20], rsp_ff[18:0]};
   assign rsp_tuser  = rsp_ff[19];

endmodule

### tb/sv/ecg_r_peak_detector_top_tb.sv
// Self-checking testbench of the ECG R-peak detector top level
module ecg_r_peak_detector_top_tb;

   typedef struct {
      bit               detected;
      bit               accepted;
      bit               ivalid;
      bit [15:0]        interval;
      bit               dvalid;
      bit [23:0]        dvalue;
   } beat_result_type;

   class beat_scoreboard_type;
      beat_result_type pending[$];
      int           errors;
      int           n_samples, n_beats, n_intervals, n_decim;
      // predictor state
      longint smooth, rise_a, fall_a, rise_pk, fall_pk;
      int     since_rise, since_fall, since_bt;
      longint rise_smp, fall_smp;
      bit [31:0] last_ms;
      bit [4:0]  win_cnt;
      longint    win_sum;
      bit [4:0]  decim_len;
      bit [7:0]  pair_win, settle;
      bit [9:0]  refr;
      bit [15:0] max_iv;

      function void clear();
         smooth = 0; rise_a = 0; fall_a = 0; rise_pk = 0; fall_pk = 0;
         since_rise = 0; since_fall = 0; since_bt = 0;
         rise_smp = 0; fall_smp = 0; last_ms = 0; win_cnt = 0; win_sum = 0;
         decim_len = 8; pair_win = 70; settle = 30; refr = 150; max_iv = 2000;
      endfunction

      function void set_reg(bit [erpd_pkg::CSR_IDX_BITS-1:0] idx, bit [15:0] val);
         case (idx)
            erpd_pkg::CSR_DECIM:  decim_len = val[4:0];
            erpd_pkg::CSR_PAIR:   pair_win  = val[7:0];
            erpd_pkg::CSR_SETTLE: settle    = val[7:0];
            erpd_pkg::CSR_REFR:   refr      = val[9:0];
            erpd_pkg::CSR_MAXIV:  max_iv    = val;
            default: ;
         endcase
      endfunction

      function longint scale(longint a, longint k);
         return (a * k) >>> erpd_pkg::FRAC_BITS;
      endfunction

      function int bump(int c);
         return (c < 65535) ? c + 1 : 65535;
      endfunction

      function void note_sample(bit [23:0] raw, bit [31:0] now);
         beat_result_type r;
         longint v, prev, dv, val;
         bit [31:0] gap;
         int len;
         r = '{default: 0};
         v = longint'($signed(raw));
         prev = smooth;
         smooth = scale(smooth, erpd_pkg::K90) + v * erpd_pkg::K10;
         dv = smooth - prev;
         rise_a = scale(rise_a, erpd_pkg::K95);
         fall_a = scale(fall_a, erpd_pkg::K95);
         if (dv > 0) rise_a += scale(dv, erpd_pkg::K05);
         else fall_a += scale(-dv, erpd_pkg::K05);
         rise_pk = scale(rise_pk, erpd_pkg::K999);
         fall_pk = scale(fall_pk, erpd_pkg::K999);
         if (rise_a > rise_pk) begin
            since_rise = 0; rise_pk = rise_a; rise_smp = v;
            if (since_fall < pair_win) begin
               r.detected = 1; since_bt = 0;
            end
         end
         if (fall_a > fall_pk) begin
            since_fall = 0; fall_pk = fall_a; fall_smp = v;
            if (since_rise < pair_win) begin
               r.detected = 1; since_bt = 0;
            end
         end
         if (since_bt == settle) begin
            gap = now - last_ms;
            if (gap > refr) begin
               r.accepted = 1; last_ms = now;
               if (gap < max_iv) begin
                  r.ivalid = 1; r.interval = gap[15:0];
               end
            end
         end
         since_fall = bump(since_fall);
         since_rise = bump(since_rise);
         since_bt   = bump(since_bt);
         len = (decim_len == 0) ? 1 : decim_len;
         win_cnt = win_cnt + 1;
         win_sum += v;
         if (win_cnt >= len) begin
            val = win_sum / len;
            win_cnt = 0; win_sum = 0;
            if (since_fall <= len) val = fall_smp;
            if (since_rise <= len) val = rise_smp;
            r.dvalid = 1; r.dvalue = val[23:0];
         end
         n_samples++;
         if (r.accepted) n_beats++;
         if (r.ivalid) n_intervals++;
         if (r.dvalid) n_decim++;
         pending.push_back(r);
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch in %s: got %0h, expected %0h", what, got, want);
         errors++;
      endtask

      task check_result(bit [47:0] d, bit u);
         beat_result_type e;
         if (pending.size() == 0) begin
            report("unexpected transaction", d, 0);
            return;
         end
         e = pending.pop_front();
         if (d[0] != e.detected)     report("beat_detected", d[0], e.detected);
         if (d[1] != e.accepted)     report("beat_accepted", d[1], e.accepted);
         if (d[2] != e.ivalid)       report("interval_valid", d[2], e.ivalid);
         if (d[18:3] != e.interval)  report("interval_ms", d[18:3], e.interval);
         if (d[42:19] != e.dvalue)   report("decimated_value", d[42:19], e.dvalue);
         if (d[47:43] != 0)          report("tdata padding", d[47:43], 0);
         if (u != e.dvalid)          report("decimated_valid", u, e.dvalid);
      endtask
   endclass

   logic                                clock = 0;
   logic                                reset = 1;
   logic                                req_tvalid = 0;
   logic                                req_tready;
   logic [55:0]                         req_tdata = '0;
   logic                                rsp_tvalid;
   logic                                rsp_tready = 0;
   logic [47:0]                         rsp_tdata;
   logic                                rsp_tuser;
   logic                                csr_wr_en = 0;
   logic [erpd_pkg::CSR_IDX_BITS-1:0]   csr_index = '0;
   logic [erpd_pkg::CSR_DATA_BITS-1:0]  csr_wdata = '0;

   beat_scoreboard_type sb = new();
   int  gap_pct = 0, stall_pct = 0;
   int  quiet_cycles = 0;
   int  wave_pos = 0, wave_period = 60, wave_amp = 1000000;
   bit [31:0] clock_ms = 32'hFFFF_FF00;

   ecg_r_peak_detector_top i_dut (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_sample(req_tdata[23:0], req_tdata[55:24]);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
      end
   end

   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= stall_pct);

   // watchdog on transaction-free cycles
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 20000) begin
         $display("watchdog expired, %0d results outstanding", sb.pending.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   task write_reg(bit [erpd_pkg::CSR_IDX_BITS-1:0] idx, bit [15:0] val);
      @(posedge clock);
      csr_wr_en <= 1; csr_index <= idx; csr_wdata <= val;
      sb.set_reg(idx, val);
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   task drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task set_config(int dl, int pw, int sd, int rf, int mx);
      drain();
      write_reg(erpd_pkg::CSR_DECIM, 16'(dl));
      write_reg(erpd_pkg::CSR_PAIR, 16'(pw));
      write_reg(erpd_pkg::CSR_SETTLE, 16'(sd));
      write_reg(erpd_pkg::CSR_REFR, 16'(rf));
      write_reg(erpd_pkg::CSR_MAXIV, 16'(mx));
   endtask

   task send_sample(bit [23:0] s, bit [31:0] t);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {t, s};
      do @(posedge clock); while (!req_tready);
   endtask

   task idle_input();
      req_tvalid <= 0;
      @(posedge clock);
   endtask

   // synthetic ECG: sharp up/down spike each period over small noise
   function bit [23:0] next_wave();
      int v;
      if (wave_pos == 0) begin
         wave_amp = $urandom_range(8000000, 50000);
         wave_period = $urandom_range(90, 25);
      end
      if (wave_pos < 4) v = wave_amp / 4 * (wave_pos + 1);
      else if (wave_pos < 8) v = -(wave_amp / 4) * (8 - wave_pos);
      else v = $urandom_range(2000) - 1000;
      wave_pos = (wave_pos + 1 >= wave_period) ? 0 : wave_pos + 1;
      return v[23:0];
   endfunction

   task run_wave(int n, int max_step);
      bit [23:0] s;
      repeat (n) begin
         if ($urandom_range(9) == 0) s = 24'($urandom);
         else s = next_wave();
         if ($urandom_range(49) == 0) clock_ms += $urandom;
         else clock_ms += $urandom_range(max_step, 1);
         send_sample(s, clock_ms);
      end
   endtask

   initial begin
      sb.clear();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: field extremes, slope peaks, zero-gap time
      send_sample(24'h7FFFFF, 32'h0);
      send_sample(24'h800000, 32'hFFFF_FFFF);
      send_sample(24'h000000, 32'h0);
      send_sample(24'hFFFFFF, 32'h8000_0000);
      send_sample(24'h7FFFFF, 32'h1);
      send_sample(24'h800000, 32'h2);
      repeat (14) begin
         clock_ms += 7;
         send_sample(next_wave(), clock_ms);
      end
      idle_input();

      set_config(8, 70, 30, 150, 2000);
      run_wave(150, 6);
      idle_input();

      set_config(1, 255, 0, 0, 65535);
      gap_pct = 77;
      run_wave(100, 20);
      idle_input();

      // pause until every pending result is back
      drain();
      set_config(0, 0, 255, 1023, 0);
      gap_pct = 0; stall_pct = 77;
      run_wave(100, 3);
      idle_input();

      set_config(16, 20, 5, 50, 300);
      gap_pct = 23; stall_pct = 23;
      run_wave(150, 8);
      idle_input();

      set_config(31, 128, 10, 1023, 65535);
      gap_pct = 0; stall_pct = 0;
      run_wave(50, 40);
      idle_input();

      set_config(3, 255, 3, 10, 1000);
      gap_pct = 23; stall_pct = 77;
      repeat (100) begin
         clock_ms += $urandom_range(30);
         send_sample(24'($urandom), clock_ms);
      end
      idle_input();

      drain();
      $display("samples %0d, accepted beats %0d, intervals %0d, decimated values %0d",
               sb.n_samples, sb.n_beats, sb.n_intervals, sb.n_decim);
      $display("covered six register settings, sender gaps and receiver stalls");
      if (sb.errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule
